### rtl/ahs_pkg.sv
// Package for the axis homing sequencer: field widths, register indexes,
// the one-hot phase type and its conversion to the external phase number.
// No dependencies.
`timescale 1ns / 1ps

package ahs_pkg;

    localparam int JOINT_W = 3;
    localparam int POS_W   = 32;
    localparam int SPEED_W = 16;
    localparam int PHASE_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JOINT_INDEX     = 3'd0,
        CFG_FAST_SPEED      = 3'd1,
        CFG_SLOW_SPEED      = 3'd2,
        CFG_SEEK_DISTANCE   = 3'd3,
        CFG_RETURN_DISTANCE = 3'd4
    } cfg_idx_t;

    // Homing phases, one-hot
    typedef enum logic [9:0] {
        PH_SEEK_ENTRY = 10'b00_0000_0001,
        PH_SEEK       = 10'b00_0000_0010,
        PH_BACK_ENTRY = 10'b00_0000_0100,
        PH_BACK       = 10'b00_0000_1000,
        PH_APPR_ENTRY = 10'b00_0001_0000,
        PH_APPR       = 10'b00_0010_0000,
        PH_RET_ENTRY  = 10'b00_0100_0000,
        PH_RET        = 10'b00_1000_0000,
        PH_ZERO_WAIT  = 10'b01_0000_0000,
        PH_DONE       = 10'b10_0000_0000
    } phase_t;

    // External phase numbers
    localparam logic [PHASE_W-1:0] PHASE_SEEK_ENTRY = 4'd0;
    localparam logic [PHASE_W-1:0] PHASE_SEEK       = 4'd1;
    localparam logic [PHASE_W-1:0] PHASE_BACK_ENTRY = 4'd2;
    localparam logic [PHASE_W-1:0] PHASE_BACK       = 4'd3;
    localparam logic [PHASE_W-1:0] PHASE_APPR_ENTRY = 4'd4;
    localparam logic [PHASE_W-1:0] PHASE_APPR       = 4'd5;
    localparam logic [PHASE_W-1:0] PHASE_RET_ENTRY  = 4'd6;
    localparam logic [PHASE_W-1:0] PHASE_RET        = 4'd7;
    localparam logic [PHASE_W-1:0] PHASE_ZERO_WAIT  = 4'd8;
    localparam logic [PHASE_W-1:0] PHASE_DONE       = 4'd9;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_SEEK_ENTRY: code = PHASE_SEEK_ENTRY;
            PH_SEEK:       code = PHASE_SEEK;
            PH_BACK_ENTRY: code = PHASE_BACK_ENTRY;
            PH_BACK:       code = PHASE_BACK;
            PH_APPR_ENTRY: code = PHASE_APPR_ENTRY;
            PH_APPR:       code = PHASE_APPR;
            PH_RET_ENTRY:  code = PHASE_RET_ENTRY;
            PH_RET:        code = PHASE_RET;
            PH_ZERO_WAIT:  code = PHASE_ZERO_WAIT;
            PH_DONE:       code = PHASE_DONE;
            default:       code = PHASE_SEEK_ENTRY;
        endcase
        return code;
    endfunction

endpackage

### rtl/ahs_item_if.sv
// Input channel of the axis homing sequencer: one control tick per word.
// Depends on ahs_pkg.
`timescale 1ns / 1ps

interface ahs_item_if
    import ahs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic               switch_level;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] current_target;
    logic               zero_pending;

    modport source (output valid, mode, switch_level, position, current_target,
                    zero_pending, input ready);
    modport sink   (input valid, mode, switch_level, position, current_target,
                    zero_pending, output ready);
endinterface

### rtl/ahs_result_if.sv
// Result channel of the axis homing sequencer: the writes and requests of one tick.
// Depends on ahs_pkg.
`timescale 1ns / 1ps

interface ahs_result_if
    import ahs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [JOINT_W-1:0]      joint;
    logic                    target_write;
    logic signed [POS_W-1:0] new_target;
    logic                    speed_write;
    logic [SPEED_W-1:0]      speed_value;
    logic                    stop_request;
    logic                    zero_request;
    logic [PHASE_W-1:0]      phase;
    logic                    done_res;

    modport source (output valid, joint, target_write, new_target, speed_write,
                    speed_value, stop_request, zero_request, phase, done_res,
                    input ready);
    modport sink   (input valid, joint, target_write, new_target, speed_write,
                    speed_value, stop_request, zero_request, phase, done_res,
                    output ready);
endinterface

### rtl/ahs_cfg_if.sv
// Configuration write channel of the axis homing sequencer.
// Depends on ahs_pkg.
`timescale 1ns / 1ps

interface ahs_cfg_if
    import ahs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/axis_homing_sequencer.sv
// Axis homing sequencer top level: input register, phase logic, result register.
// Depends on ahs_pkg, ahs_item_if, ahs_result_if and ahs_cfg_if.
`timescale 1ns / 1ps

// Usage
//   items   : one word per control tick (mode, switch level, position, current
//             target, zero pending). Accepted when valid and ready are high.
//   results : one word per accepted item, in order, with the target and speed
//             writes, stop and zero requests, the phase after the tick and done.
//   cfg     : register writes (index 0 joint, 1 fast speed, 2 slow speed,
//             3 seek distance, 4 return distance); always ready. Indexes 5 to 7
//             are ignored. Write only while no item is in flight.
//   Path    : an accepted item is held in the input register, then in the result register.
//   Throughput: one item per cycle while results.ready is high; the phase register is updated as the item
//             passes from the input register to the result register.
//   Stall   : a result held by a low results.ready stays put; the input
//             register still takes one more word if empty, then items.ready drops.
//   Reset   : phase returns to seek entry, configuration registers to 0, both
//             stages empty.
module axis_homing_sequencer
    import ahs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ahs_item_if.sink      items,
    ahs_result_if.source  results,
    ahs_cfg_if.sink       cfg
);

    // Configuration registers
    logic [JOINT_W-1:0]      joint_index_reg;
    logic [SPEED_W-1:0]      fast_speed_reg;
    logic [SPEED_W-1:0]      slow_speed_reg;
    logic [POS_W-1:0]        seek_distance_reg;
    logic [POS_W-1:0]        return_distance_reg;

    // Input stage
    logic                    item_valid_reg;
    logic                    item_mode_reg;
    logic                    item_switch_reg;
    logic [POS_W-1:0]        item_position_reg;
    logic [POS_W-1:0]        item_target_reg;
    logic                    item_zpend_reg;

    // Phase state
    phase_t                  phase_reg;
    phase_t                  phase_next;

    // Result stage
    logic                    res_valid_reg;
    logic                    res_twr_reg;
    logic [POS_W-1:0]        res_target_reg;
    logic                    res_swr_reg;
    logic [SPEED_W-1:0]      res_speed_reg;
    logic                    res_stop_reg;
    logic                    res_zreq_reg;
    logic [PHASE_W-1:0]      res_phase_reg;

    // Combinational results of one tick
    logic                    twr_next;
    logic [POS_W-1:0]        target_next;
    logic                    swr_next;
    logic [SPEED_W-1:0]      speed_next;
    logic                    stop_next;
    logic                    zreq_next;
    logic [POS_W-1:0]        offset;
    phase_t                  phase_start;

    logic                    res_free;
    logic                    advance;

    // Flow control
    assign res_free    = !res_valid_reg || results.ready;
    assign advance     = item_valid_reg && res_free;
    assign items.ready = !item_valid_reg || res_free;
    assign cfg.ready   = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint_index_reg     <= '0;
            fast_speed_reg      <= '0;
            slow_speed_reg      <= '0;
            seek_distance_reg   <= '0;
            return_distance_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_JOINT_INDEX:     joint_index_reg     <= cfg.data[JOINT_W-1:0];
                CFG_FAST_SPEED:      fast_speed_reg      <= cfg.data[SPEED_W-1:0];
                CFG_SLOW_SPEED:      slow_speed_reg      <= cfg.data[SPEED_W-1:0];
                CFG_SEEK_DISTANCE:   seek_distance_reg   <= cfg.data[POS_W-1:0];
                CFG_RETURN_DISTANCE: return_distance_reg <= cfg.data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            item_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.ready && items.valid)
        begin
            item_mode_reg     <= items.mode;
            item_switch_reg   <= items.switch_level;
            item_position_reg <= items.position;
            item_target_reg   <= items.current_target;
            item_zpend_reg    <= items.zero_pending;
        end
    end

    // Phase logic for one tick; restart forces seek entry first
    always_comb
    begin
        phase_start = item_mode_reg ? PH_SEEK_ENTRY : phase_reg;
        phase_next  = phase_start;
        twr_next    = 1'b0;
        swr_next    = 1'b0;
        speed_next  = '0;
        stop_next   = 1'b0;
        zreq_next   = 1'b0;
        offset      = '0;
        unique case (phase_start)
            PH_SEEK_ENTRY:
            begin
                swr_next   = 1'b1;
                speed_next = fast_speed_reg;
                twr_next   = 1'b1;
                offset     = seek_distance_reg;
                phase_next = PH_SEEK;
            end
            PH_SEEK:
            begin
                if (!item_switch_reg)
                begin
                    stop_next  = 1'b1;
                    phase_next = PH_BACK_ENTRY;
                end
            end
            PH_BACK_ENTRY:
            begin
                // entry falls through into the release check in the same tick
                swr_next   = 1'b1;
                speed_next = slow_speed_reg;
                twr_next   = 1'b1;
                offset     = -{seek_distance_reg[POS_W-2:0], 1'b0};
                phase_next = PH_BACK;
                if (item_switch_reg)
                begin
                    stop_next  = 1'b1;
                    phase_next = PH_APPR_ENTRY;
                end
            end
            PH_BACK:
            begin
                if (item_switch_reg)
                begin
                    stop_next  = 1'b1;
                    phase_next = PH_APPR_ENTRY;
                end
            end
            PH_APPR_ENTRY:
            begin
                twr_next   = 1'b1;
                offset     = {seek_distance_reg[POS_W-2:0], 1'b0};
                phase_next = PH_APPR;
            end
            PH_APPR:
            begin
                if (!item_switch_reg)
                begin
                    stop_next  = 1'b1;
                    phase_next = PH_RET_ENTRY;
                end
            end
            PH_RET_ENTRY:
            begin
                swr_next   = 1'b1;
                speed_next = fast_speed_reg;
                twr_next   = 1'b1;
                offset     = return_distance_reg;
                phase_next = PH_RET;
            end
            PH_RET:
            begin
                if (item_target_reg == item_position_reg)
                begin
                    zreq_next  = 1'b1;
                    phase_next = PH_ZERO_WAIT;
                end
            end
            PH_ZERO_WAIT:
            begin
                if (!item_zpend_reg)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: ;
            default: ;
        endcase
        // idle target field reads as zero
        target_next = twr_next ? (item_target_reg + offset) : '0;
    end

    // Phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK_ENTRY;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_twr_reg    <= twr_next;
            res_target_reg <= target_next;
            res_swr_reg    <= swr_next;
            res_speed_reg  <= speed_next;
            res_stop_reg   <= stop_next;
            res_zreq_reg   <= zreq_next;
            res_phase_reg  <= phase_code(phase_next);
        end
    end

    // Result word
    assign results.valid        = res_valid_reg;
    assign results.joint        = joint_index_reg;
    assign results.target_write = res_twr_reg;
    assign results.new_target   = res_target_reg;
    assign results.speed_write  = res_swr_reg;
    assign results.speed_value  = res_speed_reg;
    assign results.stop_request = res_stop_reg;
    assign results.zero_request = res_zreq_reg;
    assign results.phase        = res_phase_reg;
    assign results.done_res     = (res_phase_reg == PHASE_DONE);

    // Checks
    a_restart_to_seek: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_mode_reg |=> phase_reg == PH_SEEK && res_phase_reg == PHASE_SEEK)
        else $error("restart did not land in the seek phase");

    a_phase_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_phase_reg == phase_code(phase_reg))
        else $error("result phase differs from phase register");

    a_zero_req_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_zreq_reg |-> res_phase_reg == PHASE_ZERO_WAIT)
        else $error("zero request outside the zero wait phase");

    a_idle_target: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_twr_reg |-> res_target_reg == '0)
        else $error("idle target field not zero");

endmodule
